### design/sdp_pkg.sv
// Shared types and constants for the step/direction pulse generator.
// Used by every module of the block; has no dependencies of its own.
package sdp_pkg;

   // Request codes carried by an input item.
   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_MOVE = 2'd1;
   localparam logic [1:0] REQ_ZERO = 2'd2;

   // Status codes returned with each result item.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_CLIPPED = 2'd2;
   localparam logic [1:0] ST_NOMOVE  = 2'd3;

   // Register map: index is paddr[3:2].
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ABS_LIMIT   = 2'd0;
   localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
   localparam logic [1:0] REG_DIR_POS     = 2'd2;

   localparam logic [29:0] ABS_LIMIT_RST   = 30'd3200;
   localparam logic [15:0] HALF_PERIOD_RST = 16'd120;
   localparam logic        DIR_POS_RST     = 1'b1;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] move_pulses;
   } req_item_type;

   typedef struct packed {
      logic               step_out;
      logic               dir_out;
      logic               busy_res;
      logic signed [31:0] position;
      logic [1:0]         status;
   } rsp_item_type;

   typedef struct packed {
      logic [29:0] abs_limit;
      logic [15:0] half_period_ticks;
      logic        dir_pos_level;
   } cfg_type;

   typedef struct packed {
      logic        no_move;
      logic        clipped;
      logic        negative;
      logic [31:0] magnitude;
   } move_plan_type;

endpackage

### design/sdp_csr.sv
// Configuration registers of the pulse generator behind an APB-style port.
// Depends on sdp_pkg for the register map and the configuration struct.
module sdp_csr
   import sdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ABS_LIMIT:   cfg_in.abs_limit         = csr_pwdata[29:0];
            REG_HALF_PERIOD: cfg_in.half_period_ticks = csr_pwdata[15:0];
            REG_DIR_POS:     cfg_in.dir_pos_level     = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.abs_limit         <= ABS_LIMIT_RST;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RST;
         cfg_ff.dir_pos_level     <= DIR_POS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ABS_LIMIT:   csr_prdata = {2'b00, cfg_ff.abs_limit};
         REG_HALF_PERIOD: csr_prdata = {16'd0, cfg_ff.half_period_ticks};
         REG_DIR_POS:     csr_prdata = {31'd0, cfg_ff.dir_pos_level};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/sdp_move_calc.sv
// Clips a relative move against the symmetric soft limit and returns its
// direction and pulse count. Pure logic; depends on sdp_pkg.
module sdp_move_calc
   import sdp_pkg::*;
(
   input  logic signed [31:0] position,
   input  logic signed [31:0] move_pulses,
   input  logic [29:0]        abs_limit,
   output move_plan_type      plan
);

   logic signed [33:0] pos_w;
   logic signed [33:0] mv_w;
   logic signed [33:0] lim_w;
   logic signed [33:0] target;
   logic signed [33:0] hi_val;
   logic signed [33:0] hi_neg;
   logic signed [33:0] lo_val;
   logic signed [33:0] lo_neg;
   logic signed [33:0] mv_neg;
   logic signed [33:0] sel_val;
   logic signed [33:0] sel_neg;
   logic               mv_zero;
   logic               over;
   logic               under;

   assign pos_w = {{2{position[31]}}, position};
   assign mv_w  = {{2{move_pulses[31]}}, move_pulses};
   assign lim_w = {4'b0000, abs_limit};

   // All candidate moves and their negations are formed side by side so that
   // only a compare and a select follow the adders.
   assign target = pos_w + mv_w;
   assign hi_val = lim_w - pos_w;
   assign hi_neg = pos_w - lim_w;
   assign lo_val = -lim_w - pos_w;
   assign lo_neg = lim_w + pos_w;
   assign mv_neg = -mv_w;

   assign mv_zero = (move_pulses == 32'sd0);
   assign over    = !mv_zero && (target > lim_w);
   assign under   = !mv_zero && !over && (target < -lim_w);

   always_comb begin
      if (over) begin
         sel_val = hi_val;
         sel_neg = hi_neg;
      end else if (under) begin
         sel_val = lo_val;
         sel_neg = lo_neg;
      end else begin
         sel_val = mv_w;
         sel_neg = mv_neg;
      end
   end

   assign plan.no_move   = (sel_val == 34'sd0);
   assign plan.clipped   = over || under;
   assign plan.negative  = sel_val[33];
   assign plan.magnitude = sel_val[33] ? sel_neg[31:0] : sel_val[31:0];

endmodule

### design/sdp_motion.sv
// Motion state of the pulse generator: position, pulse count and phase timer.
// Advances once per item; depends on sdp_pkg and sdp_move_calc.
module sdp_motion
   import sdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SETUP = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_LOW   = 4'b1000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic signed [31:0] position_ff, position_in;
   logic [31:0]        pulses_left_ff, pulses_left_in;
   logic               move_negative_ff, move_negative_in;
   logic [15:0]        phase_timer_ff, phase_timer_in;
   logic               step_level_ff, step_level_in;
   logic               dir_level_ff, dir_level_in;
   logic [1:0]         status;
   logic [15:0]        half_m1;
   move_plan_type      plan;

   sdp_move_calc u_move_calc (
      .position    (position_ff),
      .move_pulses (item.move_pulses),
      .abs_limit   (cfg.abs_limit),
      .plan        (plan)
   );

   // A half period of zero behaves as one tick.
   assign half_m1 = (cfg.half_period_ticks == 16'd0) ? 16'd0 :
                    cfg.half_period_ticks - 16'd1;

   always_comb begin
      phase_in         = phase_ff;
      position_in      = position_ff;
      pulses_left_in   = pulses_left_ff;
      move_negative_in = move_negative_ff;
      phase_timer_in   = phase_timer_ff;
      step_level_in    = step_level_ff;
      dir_level_in     = dir_level_ff;
      status           = ST_OK;
      if (step_en) begin
         if (phase_ff != PH_IDLE) begin
            if (item.req_type == REQ_MOVE || item.req_type == REQ_ZERO) begin
               status = ST_BUSY;
            end
            if (phase_timer_ff != 16'd0) begin
               phase_timer_in = phase_timer_ff - 16'd1;
            end else begin
               case (phase_ff)
                  PH_HIGH: begin
                     step_level_in  = 1'b0;
                     phase_in       = PH_LOW;
                     phase_timer_in = half_m1;
                  end
                  PH_SETUP, PH_LOW: begin
                     if (phase_ff == PH_SETUP || pulses_left_ff != 32'd0) begin
                        // Rising edge of a step pulse moves the position.
                        step_level_in  = 1'b1;
                        pulses_left_in = pulses_left_ff - 32'd1;
                        position_in    = move_negative_ff ? position_ff - 32'sd1 :
                                                            position_ff + 32'sd1;
                        phase_in       = PH_HIGH;
                        phase_timer_in = half_m1;
                     end else begin
                        phase_in       = PH_IDLE;
                        phase_timer_in = 16'd0;
                        step_level_in  = 1'b0;
                     end
                  end
                  default: begin
                     phase_in       = PH_IDLE;
                     phase_timer_in = 16'd0;
                     step_level_in  = 1'b0;
                  end
               endcase
            end
         end else if (item.req_type == REQ_ZERO) begin
            position_in = 32'sd0;
         end else if (item.req_type == REQ_MOVE) begin
            if (plan.no_move) begin
               status = ST_NOMOVE;
            end else begin
               status           = plan.clipped ? ST_CLIPPED : ST_OK;
               move_negative_in = plan.negative;
               pulses_left_in   = plan.magnitude;
               dir_level_in     = ((!plan.negative) == cfg.dir_pos_level);
               step_level_in    = 1'b0;
               phase_in         = PH_SETUP;
               phase_timer_in   = half_m1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         position_ff      <= 32'sd0;
         pulses_left_ff   <= 32'd0;
         move_negative_ff <= 1'b0;
         phase_timer_ff   <= 16'd0;
         step_level_ff    <= 1'b0;
         dir_level_ff     <= DIR_POS_RST;
      end else begin
         phase_ff         <= phase_in;
         position_ff      <= position_in;
         pulses_left_ff   <= pulses_left_in;
         move_negative_ff <= move_negative_in;
         phase_timer_ff   <= phase_timer_in;
         step_level_ff    <= step_level_in;
         dir_level_ff     <= dir_level_in;
      end
   end

   assign result.step_out = step_level_in;
   assign result.dir_out  = dir_level_in;
   assign result.busy_res = (phase_in != PH_IDLE);
   assign result.position = position_in;
   assign result.status   = status;

`ifndef ASSERT_OFF
   a_step_only_busy: assert property (@(posedge clock) disable iff (reset)
      step_level_ff |-> (phase_ff == PH_HIGH))
      else $error("step pin high outside the high phase");

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (phase_timer_ff == 16'd0))
      else $error("phase timer running while idle");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register lost its one-hot code");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> ($stable(position_ff) && $stable(phase_ff) &&
                    $stable(pulses_left_ff)))
      else $error("motion state changed without an item");
`endif

endmodule

### design/step_dir_pulse_generator_unit.sv
// Step/direction pulse generator: one item per clock tick, one result per item.
// A result is registered in the result register after its item is held in the input register.
// Throughput: one item per cycle while the result side is not stalled; the motion state updates once per item.
// Reset (synchronous, active high) clears the valid flags of both pipeline
// registers and the motion state, and loads limit 3200, half period 120 and level 1.
module step_dir_pulse_generator_unit
   import sdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;
   rsp_item_type result;
   logic         out_free;
   logic         step_en;

   sdp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The stored item is worked on only when the result register can take it.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step_en;

   sdp_motion u_motion (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input held off without a stalled result");

   a_work_fills_output: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid)
      else $error("processed item did not reach the result register");

   a_no_result_from_nothing: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !in_valid_ff) |=> !rsp_valid)
      else $error("result appeared with no item in flight");
`endif

endmodule

### dv/step_dir_pulse_generator_unit_tb.sv
// Self-checking testbench for the step/direction pulse generator unit.
// Depends on sdp_pkg and step_dir_pulse_generator_unit; predicts every result
// item from a tick-level model of the motion state kept inside this file, or from a fixed row.
`timescale 1ns / 1ps

module step_dir_pulse_generator_unit_tb
   import sdp_pkg::*;
();

   localparam logic [1:0]  REQ_SPARE    = 2'd3;
   localparam logic [31:0] PULSES_MIN   = 32'h8000_0000;
   localparam logic [31:0] PULSES_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] LIMIT_MAX    = 32'h3FFF_FFFF;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          MAX_REPORTS  = 40;
   localparam int          SEGMENTS     = 6;
   localparam int          SEG_ITEMS    = 150;
   localparam longint      CYCLE_LIMIT  = 2_000_000;

   typedef enum logic [1:0] {
      MOTION_IDLE, MOTION_SETUP, MOTION_HIGH, MOTION_LOW
   } motion_phase_type;
   typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_SETTLE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      req_item_type  item;
      bit            typed;
      rsp_item_type  want;
      logic [1:0]    reg_idx;
      logic [31:0]   value;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predicted motion state and register copy.
   cfg_type            cfg_q;
   logic signed [31:0] pos_q;
   logic [31:0]        left_q;
   bit                 neg_q;
   motion_phase_type   ph_q;
   logic [15:0]        timer_q;
   bit                 step_q;
   bit                 dir_q;

   rsp_item_type pending_pin_states[$];
   plan_row_type plan[$];
   int           error_count = 0;
   longint       cycle_count = 0;
   bit           pace_on = 1'b1;
   int           idle_pct = 20;
   bit           hold_request = 1'b0;
   int           stall_left = 0;

   step_dir_pulse_generator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[step_dir_pulse_generator_unit] ERROR");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      if (error_count < MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   function automatic int pause_len();
      if (!pace_on || $urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] half_reload();
      // A half period of zero behaves like one tick.
      return (cfg_q.half_period_ticks == 16'd0) ? 16'd0 : cfg_q.half_period_ticks - 16'd1;
   endfunction

   task automatic begin_step_pulse();
      step_q  = 1'b1;
      left_q  = left_q - 32'd1;
      pos_q   = neg_q ? pos_q - 32'sd1 : pos_q + 32'sd1;
      ph_q    = MOTION_HIGH;
      timer_q = half_reload();
   endtask

   // One tick of the pulse generator; returns the pin levels after the tick.
   task automatic step_motion(input req_item_type it, output rsp_item_type view);
      logic [1:0] verdict;
      longint     mv;
      longint     here;
      longint     lim;
      longint     aim;
      bit         clipped;
      verdict = ST_OK;
      if (ph_q != MOTION_IDLE) begin
         if (it.req_type == REQ_MOVE || it.req_type == REQ_ZERO) verdict = ST_BUSY;
         if (timer_q != 16'd0) begin
            timer_q = timer_q - 16'd1;
         end else begin
            case (ph_q)
               MOTION_SETUP: begin_step_pulse();
               MOTION_HIGH: begin
                  step_q  = 1'b0;
                  ph_q    = MOTION_LOW;
                  timer_q = half_reload();
               end
               default: begin
                  if (left_q != 32'd0) begin
                     begin_step_pulse();
                  end else begin
                     ph_q    = MOTION_IDLE;
                     timer_q = 16'd0;
                     step_q  = 1'b0;
                  end
               end
            endcase
         end
      end else if (it.req_type == REQ_ZERO) begin
         pos_q = 32'sd0;
      end else if (it.req_type == REQ_MOVE) begin
         mv      = $signed(it.move_pulses);
         here    = pos_q;
         lim     = cfg_q.abs_limit;
         clipped = 1'b0;
         // The target is formed 64 bits wide, so extreme moves cannot wrap.
         if (mv != 0) begin
            aim = here + mv;
            if (aim > lim) begin
               mv = lim - here;
               clipped = 1'b1;
            end else if (aim < -lim) begin
               mv = -lim - here;
               clipped = 1'b1;
            end
         end
         if (mv == 0) begin
            verdict = ST_NOMOVE;
         end else begin
            verdict = clipped ? ST_CLIPPED : ST_OK;
            neg_q   = (mv < 0);
            left_q  = 32'(neg_q ? -mv : mv);
            dir_q   = ((!neg_q) == cfg_q.dir_pos_level);
            step_q  = 1'b0;
            ph_q    = MOTION_SETUP;
            timer_q = half_reload();
         end
      end
      view = {step_q, dir_q, ph_q != MOTION_IDLE, pos_q, verdict};
   endtask

   // Offers one item and holds it until accepted; the expectation is queued on acceptance.
   task automatic send_request(input req_item_type it, input bit typed, input rsp_item_type want);
      int           gap;
      rsp_item_type view;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      step_motion(it, view);
      pending_pin_states.push_back(typed ? want : view);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_pin_states.size() > 0) @(posedge clock);
   endtask

   task automatic send_tick();
      req_item_type it;
      it.req_type    = REQ_TICK;
      it.move_pulses = $urandom();
      send_request(it, 1'b0, '0);
   endtask

   // Writes one register, mirrors it, and reads it back.
   task automatic csr_update(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_pready !== 1'b1)
         flag_mismatch("register pready", 1, csr_pready);
      case (idx)
         REG_ABS_LIMIT:   cfg_q.abs_limit = value[29:0];
         REG_HALF_PERIOD: cfg_q.half_period_ticks = value[15:0];
         default:         cfg_q.dir_pos_level = value[0];
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ABS_LIMIT:   readback = {2'b00, cfg_q.abs_limit};
         REG_HALF_PERIOD: readback = {16'd0, cfg_q.half_period_ticks};
         default:         readback = {31'd0, cfg_q.dir_pos_level};
      endcase
      if (csr_prdata !== readback)
         flag_mismatch("register readback", readback, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (pending_pin_states.size() == 0) begin
         flag_mismatch("unexpected result item, status", -1, got.status);
         return;
      end
      want = pending_pin_states.pop_front();
      if (got.step_out !== want.step_out) flag_mismatch("step_out", want.step_out, got.step_out);
      if (got.dir_out !== want.dir_out) flag_mismatch("dir_out", want.dir_out, got.dir_out);
      if (got.busy_res !== want.busy_res) flag_mismatch("busy_res", want.busy_res, got.busy_res);
      if (got.position !== want.position) flag_mismatch("position", want.position, got.position);
      if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
   endtask

   // Result side: checks accepted items and stalls at random, or for one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (stall_left == 0) begin
            if (hold_request) begin
               stall_left   = HOLD_CYCLES;
               hold_request = 1'b0;
            end else begin
               stall_left = pause_len();
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic plan_row_type item_row(input logic [1:0] code, input logic [31:0] pulses);
      plan_row_type r;
      r.kind             = ROW_ITEM;
      r.item.req_type    = code;
      r.item.move_pulses = pulses;
      r.typed            = 1'b0;
      r.want             = '0;
      r.reg_idx          = REG_ABS_LIMIT;
      r.value            = '0;
      return r;
   endfunction

   // Result of an idle tick, for rows whose outcome is plain to see.
   function automatic plan_row_type known_row(input logic [1:0] code, input logic [31:0] pulses,
                                              input bit dir, input logic [31:0] pos,
                                              input logic [1:0] st);
      plan_row_type r;
      r       = item_row(code, pulses);
      r.typed = 1'b1;
      r.want  = {1'b0, dir, 1'b0, pos, st};
      return r;
   endfunction

   function automatic plan_row_type cfg_row(input logic [1:0] idx, input logic [31:0] value);
      plan_row_type r;
      r         = item_row(REQ_TICK, '0);
      r.kind    = ROW_CFG;
      r.reg_idx = idx;
      r.value   = value;
      return r;
   endfunction

   function automatic plan_row_type settle_row();
      plan_row_type r;
      r      = item_row(REQ_TICK, '0);
      r.kind = ROW_SETTLE;
      return r;
   endfunction

   function automatic req_item_type random_request();
      req_item_type it;
      int unsigned  roll;
      it.move_pulses = $urandom();
      roll = $urandom_range(0, 99);
      // Moves land mostly on an idle generator; while busy they test rejection.
      if (ph_q == MOTION_IDLE)
         it.req_type = (roll < 45) ? REQ_MOVE : (roll < 55) ? REQ_ZERO :
                       (roll < 62) ? REQ_SPARE : REQ_TICK;
      else
         it.req_type = (roll < 8) ? REQ_MOVE : (roll < 12) ? REQ_ZERO :
                       (roll < 16) ? REQ_SPARE : REQ_TICK;
      if (it.req_type == REQ_MOVE) begin
         roll = $urandom_range(0, 99);
         if (cfg_q.abs_limit > 30'd64)
            it.move_pulses = $urandom_range(0, 16) - 8;
         else if (roll < 60)
            it.move_pulses = $urandom_range(0, 40) - 20;
         else if (roll < 80)
            case ($urandom_range(0, 3))
               0:       it.move_pulses = PULSES_MIN;
               1:       it.move_pulses = PULSES_MAX;
               2:       it.move_pulses = PULSES_MIN + 32'd1;
               default: it.move_pulses = 32'hFFFF_FFFF;
            endcase
      end
      return it;
   endfunction

   initial begin
      plan_row_type row;
      int           seg;

      cfg_q   = {ABS_LIMIT_RST, HALF_PERIOD_RST, DIR_POS_RST};
      pos_q   = 32'sd0;
      left_q  = 32'd0;
      neg_q   = 1'b0;
      ph_q    = MOTION_IDLE;
      timer_q = 16'd0;
      step_q  = 1'b0;
      dir_q   = DIR_POS_RST;

      plan.push_back(known_row(REQ_TICK, 32'd0, 1'b1, 32'd0, ST_OK));
      plan.push_back(known_row(REQ_SPARE, PULSES_MAX, 1'b1, 32'd0, ST_OK));
      plan.push_back(known_row(REQ_ZERO, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_OK));
      plan.push_back(known_row(REQ_MOVE, 32'd0, 1'b1, 32'd0, ST_NOMOVE));
      plan.push_back(cfg_row(REG_HALF_PERIOD, 32'd1));
      plan.push_back(item_row(REQ_MOVE, 32'd2));
      plan.push_back(item_row(REQ_MOVE, 32'd5));
      plan.push_back(item_row(REQ_ZERO, 32'd0));
      plan.push_back(settle_row());
      plan.push_back(known_row(REQ_ZERO, 32'd0, 1'b1, 32'd0, ST_OK));
      plan.push_back(cfg_row(REG_DIR_POS, 32'd0));
      plan.push_back(cfg_row(REG_ABS_LIMIT, 32'd5));
      plan.push_back(item_row(REQ_MOVE, PULSES_MIN));
      plan.push_back(settle_row());
      // From below zero, the most negative move must not wrap into a positive target.
      plan.push_back(known_row(REQ_MOVE, PULSES_MIN, 1'b1, -32'sd5, ST_NOMOVE));
      plan.push_back(item_row(REQ_MOVE, PULSES_MAX));
      plan.push_back(settle_row());
      // Position now lies outside the new limit, so clipping reverses the move.
      plan.push_back(cfg_row(REG_ABS_LIMIT, 32'd2));
      plan.push_back(item_row(REQ_MOVE, 32'd3));
      plan.push_back(settle_row());
      plan.push_back(cfg_row(REG_ABS_LIMIT, 32'd0));
      plan.push_back(item_row(REQ_MOVE, 32'd7));
      plan.push_back(settle_row());
      plan.push_back(known_row(REQ_MOVE, 32'hFFFF_FFFF, 1'b1, 32'd0, ST_NOMOVE));
      plan.push_back(cfg_row(REG_HALF_PERIOD, 32'd0));
      plan.push_back(cfg_row(REG_ABS_LIMIT, LIMIT_MAX));
      plan.push_back(item_row(REQ_MOVE, -32'sd3));
      plan.push_back(settle_row());
      plan.push_back(cfg_row(REG_DIR_POS, 32'd1));
      plan.push_back(cfg_row(REG_HALF_PERIOD, 32'd65535));
      plan.push_back(cfg_row(REG_HALF_PERIOD, 32'd20));
      plan.push_back(item_row(REQ_MOVE, 32'd1));
      plan.push_back(item_row(REQ_TICK, 32'd0));
      plan.push_back(settle_row());

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         case (row.kind)
            ROW_ITEM: send_request(row.item, row.typed, row.want);
            ROW_CFG: begin
               drain_results();
               csr_update(row.reg_idx, row.value);
            end
            default: begin
               // Long half periods are run at full rate to keep the run short.
               pace_on = (cfg_q.half_period_ticks < 16'd16);
               while (ph_q != MOTION_IDLE) send_tick();
               pace_on = 1'b1;
            end
         endcase
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         idle_pct = (seg == 2) ? 0 : 20;
         case (seg)
            0: begin
               csr_update(REG_ABS_LIMIT, $urandom_range(0, 12));
               csr_update(REG_HALF_PERIOD, 32'd1);
            end
            1: begin
               csr_update(REG_ABS_LIMIT, 32'd0);
               csr_update(REG_HALF_PERIOD, 32'd0);
            end
            2: begin
               csr_update(REG_ABS_LIMIT, LIMIT_MAX);
               csr_update(REG_HALF_PERIOD, $urandom_range(0, 2));
            end
            3: begin
               csr_update(REG_ABS_LIMIT, $urandom_range(1, 40));
               csr_update(REG_HALF_PERIOD, $urandom_range(0, 3));
            end
            4: begin
               csr_update(REG_ABS_LIMIT, $urandom_range(0, 12));
               csr_update(REG_HALF_PERIOD, 32'd2);
            end
            default: begin
               csr_update(REG_ABS_LIMIT, $urandom_range(0, 6));
               csr_update(REG_HALF_PERIOD, 32'd1);
            end
         endcase
         csr_update(REG_DIR_POS, $urandom_range(0, 1));
         // The result side holds off once while items keep coming, to back up the block.
         if (seg == 1) hold_request = 1'b1;
         repeat (SEG_ITEMS) send_request(random_request(), 1'b0, '0);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[step_dir_pulse_generator_unit] OK");
      else
         $display("[step_dir_pulse_generator_unit] ERROR");
      $finish;
   end

endmodule
